### rtl/core/ldu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LDU sparse matrix-vector package
// Shared widths, item kinds and controller states of the LDU product engine.
// ----------------------------------------------------------------------------
package ldu_pkg;

  localparam int unsigned IdxW   = 10;
  localparam int unsigned ValW   = 32;
  localparam int unsigned SumW   = 48;
  localparam int unsigned OpW    = 2;
  localparam int unsigned LimitW = 17;

  typedef enum logic [OpW-1:0] {
    OP_LOAD     = 2'd0,
    OP_FACE     = 2'd1,
    OP_BOUNDARY = 2'd2,
    OP_READ     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WRITE,
    ST_FACE_UP,
    ST_FACE_LO,
    ST_REPLY
  } state_e;

endpackage

### rtl/core/ldu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LDU sparse matrix-vector channels
// Valid/ready channels for work items and for cell sum reports.
// ----------------------------------------------------------------------------
interface ldu_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [ldu_pkg::OpW-1:0]       operation;
  logic        [ldu_pkg::IdxW-1:0]      cell_index;
  logic        [ldu_pkg::IdxW-1:0]      other_cell_index;
  logic signed [ldu_pkg::ValW-1:0]      first_coeff;
  logic signed [ldu_pkg::ValW-1:0]      second_coeff;
  logic signed [ldu_pkg::ValW-1:0]      vector_value;

  modport source (
    output valid, operation, cell_index, other_cell_index,
           first_coeff, second_coeff, vector_value,
    input  ready
  );
  modport sink (
    input  valid, operation, cell_index, other_cell_index,
           first_coeff, second_coeff, vector_value,
    output ready
  );
endinterface

interface ldu_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [ldu_pkg::IdxW-1:0]      result_cell;
  logic signed [ldu_pkg::SumW-1:0]      cell_sum;

  modport source (
    output valid, result_cell, cell_sum,
    input  ready
  );
  modport sink (
    input  valid, result_cell, cell_sum,
    output ready
  );
endinterface

### rtl/core/ldu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LDU generic RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module ldu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/core/ldu_sparse_matvec_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LDU sparse matrix-vector unit
// Builds the rows of y = A*x for a matrix in lower-diagonal-upper face form,
// with the vector and the row sums held in two synchronous RAMs.
// ----------------------------------------------------------------------------
//   Channel   Dir  Carries
//   in_ch_i   in   operation, cell and face indexes, coefficients, vector value
//   out_ch_o  out  result_cell and saturated Q32.16 cell_sum of a read
//
// Loads and boundaries pass fetch and write, faces fetch and the upper and lower
// updates, reads the reply state; the sequencer serializes the read-modify-write
// of each cell sum via the single sum RAM read port and the shared 32x32 multiplier.
// Reset clears only the controller and output valid; the RAM contents are
// undefined until written, so there is no clearing pass.
// A waiting read result stalls only a following read, which then blocks all later items.
// ----------------------------------------------------------------------------
module ldu_sparse_matvec_unit #(
  parameter int unsigned CELLS = 1024
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  ldu_in_if.sink    in_ch_i,
  ldu_out_if.source out_ch_o
);

  localparam int unsigned AddrW = $clog2(CELLS);
  localparam logic [ldu_pkg::LimitW-1:0] CellLimit = ldu_pkg::LimitW'(CELLS);
  localparam logic signed [ldu_pkg::SumW-1:0] SumMax = {1'b0, {(ldu_pkg::SumW-1){1'b1}}};
  localparam logic signed [ldu_pkg::SumW-1:0] SumMin = {1'b1, {(ldu_pkg::SumW-1){1'b0}}};

  function automatic logic signed [ldu_pkg::SumW-1:0] sat_sum(
    input logic signed [ldu_pkg::SumW-1:0] a,
    input logic signed [ldu_pkg::SumW-1:0] b,
    input logic                            sub
  );
    logic signed [ldu_pkg::SumW:0] s;
    if (sub) begin
      s = {a[ldu_pkg::SumW-1], a} - {b[ldu_pkg::SumW-1], b};
    end else begin
      s = {a[ldu_pkg::SumW-1], a} + {b[ldu_pkg::SumW-1], b};
    end
    if (s[ldu_pkg::SumW] != s[ldu_pkg::SumW-1]) begin
      return s[ldu_pkg::SumW] ? SumMin : SumMax;
    end
    return s[ldu_pkg::SumW-1:0];
  endfunction

  function automatic logic in_range(input logic [ldu_pkg::IdxW-1:0] idx);
    return ldu_pkg::LimitW'(idx) < CellLimit;
  endfunction

  ldu_pkg::state_e state_q, state_d;

  ldu_pkg::op_e                    op_q;
  logic        [ldu_pkg::IdxW-1:0] c_q, u_q;
  logic signed [ldu_pkg::ValW-1:0] k1_q, k2_q, x_q;

  logic signed [ldu_pkg::SumW-1:0] prod_q, prod_d;
  logic signed [ldu_pkg::SumW-1:0] acc_q;
  logic                            fwd_q;
  logic signed [ldu_pkg::SumW-1:0] fwd_val_q;
  logic                            vec_ok_q, sum_ok_q;

  logic                            out_valid_q;
  logic        [ldu_pkg::IdxW-1:0] out_cell_q;
  logic signed [ldu_pkg::SumW-1:0] out_sum_q;

  logic                            accept;
  ldu_pkg::op_e                    in_op;

  logic                            vec_re, vec_we, sum_re, sum_we;
  logic        [ldu_pkg::IdxW-1:0] vec_ridx, sum_ridx, sum_widx;
  logic signed [ldu_pkg::SumW-1:0] sum_wdata;
  logic        [ldu_pkg::ValW-1:0] vec_rdata;
  logic        [ldu_pkg::SumW-1:0] sum_rdata;
  logic signed [ldu_pkg::ValW-1:0] vec_val;
  logic signed [ldu_pkg::SumW-1:0] sum_val, lo_base;
  logic                            mul_en, out_load;
  logic signed [ldu_pkg::ValW-1:0] mul_a, mul_b;
  logic signed [2*ldu_pkg::ValW-1:0] product;

  assign in_op   = ldu_pkg::op_e'(in_ch_i.operation);
  assign accept  = in_ch_i.valid && in_ch_i.ready;
  assign vec_val = vec_ok_q ? $signed(vec_rdata) : '0;
  assign sum_val = sum_ok_q ? $signed(sum_rdata) : '0;
  assign lo_base = fwd_q ? fwd_val_q : sum_val;

  assign product = mul_a * mul_b;
  assign prod_d  = product[2*ldu_pkg::ValW-1:ldu_pkg::ValW/2];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ldu_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (in_op == ldu_pkg::OP_READ) ? ldu_pkg::ST_REPLY : ldu_pkg::ST_FETCH;
        end
      end
      ldu_pkg::ST_FETCH: begin
        state_d = (op_q == ldu_pkg::OP_FACE) ? ldu_pkg::ST_FACE_UP : ldu_pkg::ST_WRITE;
      end
      ldu_pkg::ST_WRITE:   state_d = ldu_pkg::ST_IDLE;
      ldu_pkg::ST_FACE_UP: state_d = ldu_pkg::ST_FACE_LO;
      ldu_pkg::ST_FACE_LO: state_d = ldu_pkg::ST_IDLE;
      ldu_pkg::ST_REPLY: begin
        if (!out_valid_q || out_ch_o.ready) begin
          state_d = ldu_pkg::ST_IDLE;
        end
      end
      default: state_d = ldu_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs and RAM port control.
  always_comb begin
    in_ch_i.ready = 1'b0;
    vec_re        = 1'b0;
    vec_ridx      = c_q;
    vec_we        = 1'b0;
    sum_re        = 1'b0;
    sum_ridx      = c_q;
    sum_we        = 1'b0;
    sum_widx      = c_q;
    sum_wdata     = prod_q;
    mul_en        = 1'b0;
    mul_a         = k1_q;
    mul_b         = vec_val;
    out_load      = 1'b0;
    unique case (state_q)
      ldu_pkg::ST_IDLE: begin
        in_ch_i.ready = 1'b1;
        vec_re        = accept;
        vec_ridx      = in_ch_i.cell_index;
        sum_re        = accept;
        sum_ridx      = (in_op == ldu_pkg::OP_FACE) ? in_ch_i.other_cell_index
                                                     : in_ch_i.cell_index;
      end
      ldu_pkg::ST_FETCH: begin
        mul_en   = 1'b1;
        mul_b    = (op_q == ldu_pkg::OP_FACE) ? vec_val : x_q;
        vec_re   = (op_q == ldu_pkg::OP_FACE);
        vec_ridx = u_q;
      end
      ldu_pkg::ST_WRITE: begin
        vec_we    = (op_q == ldu_pkg::OP_LOAD) && in_range(c_q);
        sum_we    = in_range(c_q);
        sum_wdata = (op_q == ldu_pkg::OP_LOAD) ? prod_q : sat_sum(acc_q, prod_q, 1'b1);
      end
      ldu_pkg::ST_FACE_UP: begin
        sum_we    = in_range(u_q);
        sum_widx  = u_q;
        sum_wdata = sat_sum(acc_q, prod_q, 1'b0);
        mul_en    = 1'b1;
        mul_a     = k2_q;
        sum_re    = 1'b1;
      end
      ldu_pkg::ST_FACE_LO: begin
        sum_we    = in_range(c_q);
        sum_wdata = sat_sum(lo_base, prod_q, 1'b0);
      end
      ldu_pkg::ST_REPLY: begin
        out_load = !out_valid_q || out_ch_o.ready;
      end
      default: begin
        in_ch_i.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ldu_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= in_op;
      c_q  <= in_ch_i.cell_index;
      u_q  <= in_ch_i.other_cell_index;
      k1_q <= in_ch_i.first_coeff;
      k2_q <= in_ch_i.second_coeff;
      x_q  <= in_ch_i.vector_value;
    end
    if (vec_re) begin
      vec_ok_q <= in_range(vec_ridx);
    end
    if (sum_re) begin
      sum_ok_q <= in_range(sum_ridx);
    end
    if (mul_en) begin
      prod_q <= prod_d;
    end
    if (state_q == ldu_pkg::ST_FETCH) begin
      acc_q <= sum_val;
    end
    if (state_q == ldu_pkg::ST_FACE_UP) begin
      fwd_q     <= (c_q == u_q);
      fwd_val_q <= sum_wdata;
    end
    if (out_load) begin
      out_cell_q <= c_q;
      out_sum_q  <= sum_val;
    end
  end

  ldu_ram #(
    .WIDTH (ldu_pkg::ValW),
    .DEPTH (CELLS)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .waddr_i (AddrW'(c_q)),
    .wdata_i (x_q),
    .re_i    (vec_re),
    .raddr_i (AddrW'(vec_ridx)),
    .rdata_o (vec_rdata)
  );

  ldu_ram #(
    .WIDTH (ldu_pkg::SumW),
    .DEPTH (CELLS)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (AddrW'(sum_widx)),
    .wdata_i (sum_wdata),
    .re_i    (sum_re),
    .raddr_i (AddrW'(sum_ridx)),
    .rdata_o (sum_rdata)
  );

  assign out_ch_o.valid       = out_valid_q;
  assign out_ch_o.result_cell = out_cell_q;
  assign out_ch_o.cell_sum    = out_sum_q;

  // The lower-cell update of a face always follows its upper-cell update.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ldu_pkg::ST_FACE_LO |-> $past(state_q) == ldu_pkg::ST_FACE_UP)
    else $error("face lower update without upper update");

  // A report only appears after the reply state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ldu_pkg::ST_REPLY)
    else $error("report raised outside the reply state");

  // Every accepted transaction leaves the idle state on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ldu_pkg::ST_FETCH || state_q == ldu_pkg::ST_REPLY))
    else $error("accepted transaction not started");

  // Sum RAM writes never coincide with accepting new work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_we |-> !in_ch_i.ready)
    else $error("sum write while idle");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LDU sparse matrix-vector unit testbench
// Drives load, face, boundary and read transactions into the unit, keeps its
// own copy of the vector and row-sum stores to predict every reported sum, and
// compares each reported cell and sum with the oldest prediction. The stimulus
// starts with the format extremes, saturation and a face on a single cell, then
// runs random traffic over several idling mixes and one long output stall.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CELLS          = 1024;
  localparam int unsigned PHASE_ITEMS    = 200;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam longint      SUM_HI         = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      SUM_LO         = -SUM_HI - 1;

  typedef struct {
    ldu_pkg::op_e                        operation;
    logic        [ldu_pkg::IdxW-1:0]     cell_index;
    logic        [ldu_pkg::IdxW-1:0]     other_cell_index;
    logic signed [ldu_pkg::ValW-1:0]     first_coeff;
    logic signed [ldu_pkg::ValW-1:0]     second_coeff;
    logic signed [ldu_pkg::ValW-1:0]     vector_value;
  } ldu_item_t;

  typedef struct {
    logic        [ldu_pkg::IdxW-1:0]     result_cell;
    logic signed [ldu_pkg::SumW-1:0]     cell_sum;
  } ldu_report_t;

  class row_sum_model;
    logic signed [ldu_pkg::ValW-1:0] vector_mem [CELLS];
    logic signed [ldu_pkg::SumW-1:0] row_sum_mem [CELLS];
    ldu_report_t                     expected_sums [$];
    int unsigned                     mismatches;
    int unsigned                     reports_checked;
    int unsigned                     saturations;

    function new();
      mismatches      = 0;
      reports_checked = 0;
      saturations     = 0;
    endfunction

    static function logic signed [ldu_pkg::SumW-1:0] q_product(
      logic signed [ldu_pkg::ValW-1:0] a,
      logic signed [ldu_pkg::ValW-1:0] b
    );
      longint wide;
      wide = longint'(a) * longint'(b);
      return ldu_pkg::SumW'(wide >>> 16);
    endfunction

    function void accumulate(logic [ldu_pkg::IdxW-1:0] idx, longint delta);
      longint total;
      total = longint'(row_sum_mem[idx]) + delta;
      if (total > SUM_HI) begin
        total = SUM_HI;
        saturations++;
      end else if (total < SUM_LO) begin
        total = SUM_LO;
        saturations++;
      end
      row_sum_mem[idx] = total[ldu_pkg::SumW-1:0];
    endfunction

    function void note_item(ldu_item_t item);
      ldu_report_t report;
      case (item.operation)
        ldu_pkg::OP_LOAD: begin
          vector_mem[item.cell_index]  = item.vector_value;
          row_sum_mem[item.cell_index] = q_product(item.first_coeff, item.vector_value);
        end
        ldu_pkg::OP_FACE: begin
          accumulate(item.other_cell_index,
                     q_product(item.first_coeff, vector_mem[item.cell_index]));
          accumulate(item.cell_index,
                     q_product(item.second_coeff, vector_mem[item.other_cell_index]));
        end
        ldu_pkg::OP_BOUNDARY: begin
          accumulate(item.cell_index,
                     -longint'(q_product(item.first_coeff, item.vector_value)));
        end
        default: begin
          report.result_cell = item.cell_index;
          report.cell_sum    = row_sum_mem[item.cell_index];
          expected_sums      = {expected_sums, report};
        end
      endcase
    endfunction

    function void check_report(logic        [ldu_pkg::IdxW-1:0] result_cell,
                               logic signed [ldu_pkg::SumW-1:0] cell_sum);
      ldu_report_t want;
      if (expected_sums.size() == 0) begin
        $error("unexpected report: result_cell %0d, cell_sum %0d", result_cell, cell_sum);
        mismatches++;
        return;
      end
      want = expected_sums.pop_front();
      reports_checked++;
      if (result_cell !== want.result_cell) begin
        $error("result_cell mismatch: expected %0d, actual %0d", want.result_cell, result_cell);
        mismatches++;
      end
      if (cell_sum !== want.cell_sum) begin
        $error("cell_sum mismatch: expected %0d, actual %0d", want.cell_sum, cell_sum);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_sums.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  ldu_in_if  in_ch ();
  ldu_out_if out_ch ();

  ldu_sparse_matvec_unit #(
    .CELLS (CELLS)
  ) DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch.sink),
    .out_ch_o (out_ch.source)
  );

  row_sum_model sb;
  bit           cell_loaded [CELLS];
  int unsigned  loaded_cells [$];
  int unsigned  op_count [4];
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  bit           hold_request;
  int unsigned  idle_cycles;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic signed [ldu_pkg::ValW-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return ldu_pkg::ValW'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      3:       return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic ldu_item_t make_item(ldu_pkg::op_e op, int unsigned c, int unsigned u,
                                          logic signed [ldu_pkg::ValW-1:0] k1,
                                          logic signed [ldu_pkg::ValW-1:0] k2,
                                          logic signed [ldu_pkg::ValW-1:0] x);
    ldu_item_t item;
    item.operation        = op;
    item.cell_index       = ldu_pkg::IdxW'(c);
    item.other_cell_index = ldu_pkg::IdxW'(u);
    item.first_coeff      = k1;
    item.second_coeff     = k2;
    item.vector_value     = x;
    return item;
  endfunction

  function automatic int unsigned pick_loaded();
    return loaded_cells[$urandom_range(0, loaded_cells.size() - 1)];
  endfunction

  function automatic ldu_item_t random_read();
    return make_item(ldu_pkg::OP_READ, pick_loaded(), $urandom_range(0, CELLS - 1),
                     random_value(), random_value(), random_value());
  endfunction

  // Only cells that have been loaded are ever read, so no entry is used unwritten.
  function automatic ldu_item_t next_random_item();
    int unsigned roll;
    int unsigned idx;
    roll = $urandom_range(0, 99);
    if (loaded_cells.size() < 16 || roll < 20) begin
      if (loaded_cells.size() > 0 && $urandom_range(0, 3) == 0) idx = pick_loaded();
      else idx = $urandom_range(0, CELLS - 1);
      if (!cell_loaded[ldu_pkg::IdxW'(idx)]) begin
        cell_loaded[ldu_pkg::IdxW'(idx)] = 1'b1;
        loaded_cells = {loaded_cells, idx};
      end
      return make_item(ldu_pkg::OP_LOAD, idx, $urandom_range(0, CELLS - 1),
                       random_value(), random_value(), random_value());
    end else if (roll < 60) begin
      idx = pick_loaded();
      return make_item(ldu_pkg::OP_FACE, idx,
                       ($urandom_range(0, 9) == 0) ? idx : pick_loaded(),
                       random_value(), random_value(), random_value());
    end else if (roll < 80) begin
      return make_item(ldu_pkg::OP_BOUNDARY, pick_loaded(), $urandom_range(0, CELLS - 1),
                       random_value(), random_value(), random_value());
    end
    return random_read();
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(ldu_item_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid            <= 1'b1;
    in_ch.operation        <= item.operation;
    in_ch.cell_index       <= item.cell_index;
    in_ch.other_cell_index <= item.other_cell_index;
    in_ch.first_coeff      <= item.first_coeff;
    in_ch.second_coeff     <= item.second_coeff;
    in_ch.vector_value     <= item.vector_value;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_item(item);
    op_count[item.operation]++;
    @(negedge clk_i);
  endtask

  task automatic load_cell(int unsigned idx, logic signed [ldu_pkg::ValW-1:0] diag,
                           logic signed [ldu_pkg::ValW-1:0] x);
    if (!cell_loaded[ldu_pkg::IdxW'(idx)]) begin
      cell_loaded[ldu_pkg::IdxW'(idx)] = 1'b1;
      loaded_cells = {loaded_cells, idx};
    end
    send_item(make_item(ldu_pkg::OP_LOAD, idx, 0, diag, '0, x));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic run_directed();
    load_cell(0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    load_cell(1023, 32'sh8000_0000, 32'sh8000_0000);
    load_cell(512, 32'sh8000_0000, 32'sh7FFF_FFFF);
    load_cell(1, 32'shFFFF_FFFF, 32'sh0000_0001);
    load_cell(341, 32'sh0001_0000, 32'shFFFF_8000);
    load_cell(682, 32'sh0000_0000, 32'sh1234_5678);
    send_item(make_item(ldu_pkg::OP_READ, 1, 0, 0, 0, 0));
    send_item(make_item(ldu_pkg::OP_READ, 512, 0, 0, 0, 0));
    repeat (2) begin
      send_item(make_item(ldu_pkg::OP_FACE, 0, 1023, 32'sh7FFF_FFFF, 32'sh8000_0000, 0));
    end
    send_item(make_item(ldu_pkg::OP_READ, 1023, 0, 0, 0, 0));
    send_item(make_item(ldu_pkg::OP_READ, 0, 0, 0, 0, 0));
    repeat (2) begin
      send_item(make_item(ldu_pkg::OP_BOUNDARY, 512, 0, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF));
    end
    send_item(make_item(ldu_pkg::OP_READ, 512, 0, 0, 0, 0));
    send_item(make_item(ldu_pkg::OP_FACE, 1, 1, 32'sh8000_0000, 32'sh7FFF_FFFF, 0));
    send_item(make_item(ldu_pkg::OP_READ, 1, 0, 0, 0, 0));
    send_item(make_item(ldu_pkg::OP_FACE, 341, 682, 32'shFFFF_FFFF, 32'sh0001_0000, 0));
    send_item(make_item(ldu_pkg::OP_BOUNDARY, 682, 0, 32'sh8000_0000, 0, 32'sh8000_0000));
    send_item(make_item(ldu_pkg::OP_READ, 341, 0, 0, 0, 0));
    send_item(make_item(ldu_pkg::OP_READ, 682, 0, 0, 0, 0));
    send_item(make_item(ldu_pkg::OP_READ, 0, 1023,
                        32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF));
  endtask

  // The receiver holds off while reads keep coming, so the unit fills and stalls.
  task automatic run_output_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    for (int n = 0; n < 40; n++) begin
      send_item((n % 3 == 0) ? random_read() : next_random_item());
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      sb.check_report(out_ch.result_cell, out_ch.cell_sum);
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    sb                     = new();
    idle_cycles            = 0;
    hold_request           = 1'b0;
    send_idle_pct          = 0;
    recv_stall_pct         = 0;
    rst_ni                 = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.operation        = ldu_pkg::OP_LOAD;
    in_ch.cell_index       = '0;
    in_ch.other_cell_index = '0;
    in_ch.first_coeff      = '0;
    in_ch.second_coeff     = '0;
    in_ch.vector_value     = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_directed();
    drain_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      repeat (PHASE_ITEMS) send_item(next_random_item());
      if (phase == 3) run_output_stall();
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d predicted reports never arrived", sb.pending());
      sb.mismatches++;
    end

    $display("Sent %0d transactions: %0d loads, %0d faces, %0d boundary, %0d reads.",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[ldu_pkg::OP_LOAD], op_count[ldu_pkg::OP_FACE],
             op_count[ldu_pkg::OP_BOUNDARY], op_count[ldu_pkg::OP_READ]);
    $display("Checked %0d reported sums over four idling mixes and a long output stall.",
             sb.reports_checked);
    $display("The predictor saturated %0d sums along the way.", sb.saturations);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
